[src/fssc_pkg.sv]
// shared types, constants and codes for the force seek stepper controller
`timescale 1ns / 1ps
package fssc_pkg;

  // sizes
  localparam int WINDOW_LEN    = 5;
  localparam int FORCE_BITS    = 20;
  localparam int POSITION_BITS = 24;
  localparam int STEP_BITS     = 7;
  localparam int BUDGET_BITS   = 16;
  localparam int READS_BITS    = 8;
  localparam int ADJ_BITS      = 6;
  localparam int STATUS_BITS   = 3;
  localparam int FILL_BITS     = $clog2(WINDOW_LEN + 1);
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;

  // fixed behavior constants
  localparam int BAND                   = 800;
  localparam int MAX_ADJUST             = 30;
  localparam int BURST                  = 100;
  localparam int DEFAULT_APPROACH_LIMIT = 1000;

  // register reset values
  localparam logic [FORCE_BITS-1:0]  TARGET_RESET   = '0;
  localparam logic [FORCE_BITS-1:0]  CEILING_RESET  = '1;
  localparam logic [FORCE_BITS-1:0]  APPROACH_RESET = FORCE_BITS'(1000);
  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET   = BUDGET_BITS'(50000);
  localparam logic [READS_BITS-1:0]  READS_RESET    = READS_BITS'(50);

  // register index, taken from paddr word offset
  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_CEILING  = 3'd1,
    REG_APPROACH = 3'd2,
    REG_BUDGET   = 3'd3,
    REG_READS    = 3'd4
  } reg_idx_t;

  // seek phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_APPROACH = 2'd1,
    PH_SEEK     = 2'd2,
    PH_WINDOW   = 2'd3
  } phase_t;

  // reported status
  typedef enum logic [STATUS_BITS-1:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_ADJ      = 3'd2,
    ST_UNSTABLE = 3'd3,
    ST_BAD      = 3'd4,
    ST_IDLE     = 3'd5
  } status_t;

  typedef struct packed {
    logic                  req_type;
    logic [FORCE_BITS-1:0] force_reading;
  } in_word_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]            step_count;
    logic                            step_forward;
    logic signed [POSITION_BITS-1:0] position;
    logic [STATUS_BITS-1:0]          status;
    logic [FORCE_BITS-1:0]           settled_force;
  } out_word_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [FORCE_BITS-1:0]  target_force;
    logic [FORCE_BITS-1:0]  force_ceiling;
    logic [FORCE_BITS-1:0]  approach_force_limit;
    logic [BUDGET_BITS-1:0] approach_step_budget;
    logic [READS_BITS-1:0]  stable_read_limit;
  } cfg_t;

endpackage

[src/fssc_regs.sv]
// apb configuration registers of the force seek stepper controller
`timescale 1ns / 1ps
module fssc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fssc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [fssc_pkg::DATA_BITS-1:0] pwdata,
  output logic [fssc_pkg::DATA_BITS-1:0] prdata,
  output fssc_pkg::cfg_t                cfg
);

  logic                          wr_en;
  fssc_pkg::reg_idx_t            idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = fssc_pkg::reg_idx_t'(paddr[fssc_pkg::ADDR_BITS-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_force         <= fssc_pkg::TARGET_RESET;
      cfg.force_ceiling        <= fssc_pkg::CEILING_RESET;
      cfg.approach_force_limit <= fssc_pkg::APPROACH_RESET;
      cfg.approach_step_budget <= fssc_pkg::BUDGET_RESET;
      cfg.stable_read_limit    <= fssc_pkg::READS_RESET;
    end else if (wr_en) begin
      case (idx)
        fssc_pkg::REG_TARGET: begin
          cfg.target_force <= pwdata[fssc_pkg::FORCE_BITS-1:0];
        end
        fssc_pkg::REG_CEILING: begin
          cfg.force_ceiling <= pwdata[fssc_pkg::FORCE_BITS-1:0];
        end
        fssc_pkg::REG_APPROACH: begin
          cfg.approach_force_limit <= pwdata[fssc_pkg::FORCE_BITS-1:0];
        end
        fssc_pkg::REG_BUDGET: begin
          cfg.approach_step_budget <= pwdata[fssc_pkg::BUDGET_BITS-1:0];
        end
        fssc_pkg::REG_READS: begin
          cfg.stable_read_limit <= pwdata[fssc_pkg::READS_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      fssc_pkg::REG_TARGET:   prdata = fssc_pkg::DATA_BITS'(cfg.target_force);
      fssc_pkg::REG_CEILING:  prdata = fssc_pkg::DATA_BITS'(cfg.force_ceiling);
      fssc_pkg::REG_APPROACH: prdata = fssc_pkg::DATA_BITS'(cfg.approach_force_limit);
      fssc_pkg::REG_BUDGET:   prdata = fssc_pkg::DATA_BITS'(cfg.approach_step_budget);
      fssc_pkg::REG_READS:    prdata = fssc_pkg::DATA_BITS'(cfg.stable_read_limit);
      default:                prdata = '0;
    endcase
  end

endmodule

[src/fssc_step.sv]
// seek state and per-reading step decision
`timescale 1ns / 1ps
module fssc_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  fssc_pkg::in_word_t   in_word,
  input  fssc_pkg::cfg_t       cfg,
  output fssc_pkg::out_word_t  res
);

  localparam int PB = fssc_pkg::POSITION_BITS;
  localparam int SB = fssc_pkg::STEP_BITS;
  localparam int FB = fssc_pkg::FORCE_BITS;
  localparam int WL = fssc_pkg::WINDOW_LEN;

  fssc_pkg::phase_t                  phase, phase_next;
  logic signed [PB-1:0]              position, position_next;
  logic [fssc_pkg::ADJ_BITS-1:0]     adjust_count, adjust_count_next;
  logic [FB-1:0]                     window_values [WL];
  logic [FB-1:0]                     window_values_next [WL];
  logic [fssc_pkg::FILL_BITS-1:0]    window_fill, window_fill_next;
  logic [fssc_pkg::READS_BITS-1:0]   stable_reads, stable_reads_next;
  logic [fssc_pkg::BUDGET_BITS-1:0]  approach_remaining, approach_remaining_next;
  logic [FB-1:0]                     last_settled, last_settled_next;

  logic [FB-1:0]                     r;
  logic [FB-1:0]                     lim;
  logic [FB-1:0]                     delta;
  logic                              toward_fwd;
  logic                              same;
  logic [fssc_pkg::FILL_BITS-1:0]    fill_inc;
  logic [fssc_pkg::ADJ_BITS-1:0]     adjust_inc;
  logic [SB-1:0]                     burst;
  logic [SB-1:0]                     count;
  logic                              fwd;
  logic                              move;
  fssc_pkg::status_t                 status;
  logic signed [SB:0]                move_delta;
  logic signed [PB:0]                pos_sum;

  assign r          = in_word.force_reading;
  assign lim        = (cfg.approach_force_limit == '0) ?
                      FB'(fssc_pkg::DEFAULT_APPROACH_LIMIT) : cfg.approach_force_limit;
  assign delta      = (r > cfg.target_force) ? r - cfg.target_force : cfg.target_force - r;
  assign toward_fwd = !(cfg.target_force < r);
  assign burst      = (approach_remaining < fssc_pkg::BUDGET_BITS'(fssc_pkg::BURST)) ?
                      approach_remaining[SB-1:0] : SB'(fssc_pkg::BURST);
  assign fill_inc   = (window_fill < fssc_pkg::FILL_BITS'(WL)) ?
                      window_fill + 1'b1 : window_fill;
  assign adjust_inc = adjust_count + 1'b1;

  // all older window entries equal to this reading
  always_comb begin
    same = 1'b1;
    for (int i = 0; i < WL - 1; i++) begin
      if (window_values[i] != r) same = 1'b0;
    end
  end

  // phase decision
  always_comb begin
    phase_next              = phase;
    adjust_count_next       = adjust_count;
    window_fill_next        = window_fill;
    stable_reads_next       = stable_reads;
    approach_remaining_next = approach_remaining;
    last_settled_next       = last_settled;
    for (int i = 0; i < WL; i++) window_values_next[i] = window_values[i];
    count  = '0;
    fwd    = 1'b0;
    move   = 1'b0;
    status = fssc_pkg::ST_BUSY;

    if (in_word.req_type) begin
      // start of a new seek
      if (cfg.target_force >= cfg.force_ceiling) begin
        phase_next = fssc_pkg::PH_IDLE;
        status     = fssc_pkg::ST_BAD;
      end else begin
        adjust_count_next = '0;
        if (r == '0) begin
          phase_next              = fssc_pkg::PH_APPROACH;
          approach_remaining_next = cfg.approach_step_budget;
        end else begin
          phase_next = fssc_pkg::PH_SEEK;
        end
      end
    end else begin
      case (phase)
        fssc_pkg::PH_APPROACH: begin
          if (r > lim || approach_remaining == '0) begin
            phase_next = fssc_pkg::PH_SEEK;
          end else begin
            count                   = burst;
            fwd                     = 1'b1;
            move                    = 1'b1;
            approach_remaining_next = approach_remaining -
                                      fssc_pkg::BUDGET_BITS'(burst);
          end
        end
        fssc_pkg::PH_SEEK: begin
          if (delta >= FB'(fssc_pkg::BAND)) begin
            count = SB'(1);
            fwd   = toward_fwd;
            move  = 1'b1;
          end else begin
            phase_next        = fssc_pkg::PH_WINDOW;
            window_fill_next  = '0;
            stable_reads_next = '0;
          end
        end
        fssc_pkg::PH_WINDOW: begin
          if (stable_reads >= cfg.stable_read_limit) begin
            phase_next = fssc_pkg::PH_IDLE;
            status     = fssc_pkg::ST_UNSTABLE;
          end else begin
            stable_reads_next     = stable_reads + 1'b1;
            window_values_next[0] = r;
            for (int i = 1; i < WL; i++) window_values_next[i] = window_values[i-1];
            window_fill_next = fill_inc;
            if (fill_inc >= fssc_pkg::FILL_BITS'(WL) && same) begin
              last_settled_next = r;
              if (r == cfg.target_force) begin
                phase_next = fssc_pkg::PH_IDLE;
                status     = fssc_pkg::ST_OK;
              end else begin
                adjust_count_next = adjust_inc;
                if (adjust_inc > fssc_pkg::ADJ_BITS'(fssc_pkg::MAX_ADJUST)) begin
                  phase_next = fssc_pkg::PH_IDLE;
                  status     = fssc_pkg::ST_ADJ;
                end else begin
                  count      = SB'(1);
                  fwd        = toward_fwd;
                  move       = 1'b1;
                  phase_next = fssc_pkg::PH_SEEK;
                end
              end
            end
          end
        end
        default: begin
          phase_next = fssc_pkg::PH_IDLE;
          status     = fssc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // saturating position update
  always_comb begin
    if (!move) begin
      move_delta = '0;
    end else if (fwd) begin
      move_delta = $signed({1'b0, count});
    end else begin
      move_delta = -$signed((SB + 1)'(1));
    end
    pos_sum = $signed({position[PB-1], position}) +
              $signed({{(PB - SB){move_delta[SB]}}, move_delta});
    if (pos_sum[PB] != pos_sum[PB-1]) begin
      position_next = pos_sum[PB] ? $signed({1'b1, {(PB - 1){1'b0}}}) :
                                    $signed({1'b0, {(PB - 1){1'b1}}});
    end else begin
      position_next = pos_sum[PB-1:0];
    end
  end

  // result word
  always_comb begin
    res.step_count    = count;
    res.step_forward  = fwd;
    res.position      = position_next;
    res.status        = status;
    res.settled_force = last_settled_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= fssc_pkg::PH_IDLE;
      position           <= '0;
      adjust_count       <= '0;
      window_fill        <= '0;
      stable_reads       <= '0;
      approach_remaining <= '0;
      last_settled       <= '0;
    end else if (take) begin
      phase              <= phase_next;
      position           <= position_next;
      adjust_count       <= adjust_count_next;
      window_fill        <= window_fill_next;
      stable_reads       <= stable_reads_next;
      approach_remaining <= approach_remaining_next;
      last_settled       <= last_settled_next;
    end
  end

  // window contents, qualified by window_fill
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < WL; i++) window_values[i] <= window_values_next[i];
    end
  end

endmodule

[src/fssc_outbuf.sv]
// result register with a skid stage
`timescale 1ns / 1ps
module fssc_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  fssc_pkg::out_word_t  res,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fssc_pkg::out_word_t  out_word
);

  logic                 skid_valid;
  fssc_pkg::out_word_t  skid_word;
  logic                 slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign full      = skid_valid;

  // output slot and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // word registers
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (take) begin
        out_word <= res;
      end
    end else if (take) begin
      skid_word <= res;
    end
  end

endmodule

[src/force_seek_stepper_controller_core.sv]
// top level of the force seek stepper controller
//
//   channel  direction  handshake                payload
//   in       to block   in_valid / in_stall      in_word (req_type, force_reading)
//   out      from block out_valid / out_stall    out_word (step_count .. settled_force)
//   cfg      to block   psel / penable / pwrite  paddr, pwdata, prdata
//
// one word per cycle unless in_stall is high: each reading is decided by compare
// logic between the seek state registers and the result register.
// a result is registered before out, passing the skid stage while out is stalled.
// rst is synchronous: phase idle, position and counters zero, registers at defaults.
// a stalled result parks in a skid stage; in_stall rises only while it is occupied.
`timescale 1ns / 1ps
module force_seek_stepper_controller_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fssc_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fssc_pkg::out_word_t            out_word,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fssc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [fssc_pkg::DATA_BITS-1:0] pwdata,
  output logic [fssc_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  fssc_pkg::cfg_t       cfg;
  fssc_pkg::out_word_t  res;
  logic                 take;
  logic                 full;

  assign pready   = 1'b1;
  assign in_stall = full;
  assign take     = in_valid && !full;

  // configuration registers
  fssc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // seek state and decision
  fssc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_word (in_word),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  fssc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
